// ===== rtl/core/ecef_to_geodetic_core_assert.svh =====
// assertion macros for the ecef to geodetic core
`ifndef ECEF_TO_GEODETIC_CORE_ASSERT_SVH
`define ECEF_TO_GEODETIC_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define E2G_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("e2g assertion failed");
`define E2G_ASSERT_NEXT(label, clk, rst_n, trig, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
    else $error("e2g assertion failed");
`else
`define E2G_ASSERT(label, clk, rst_n, prop)
`define E2G_ASSERT_NEXT(label, clk, rst_n, trig, prop)
`endif
`endif

// ===== rtl/core/e2g_pkg.sv =====
`default_nettype none
package e2g_pkg;

  typedef enum logic [1:0] {SER_MUL, SER_DIV, SER_SQRT} ser_op_t;
  typedef enum logic [1:0] {SHR_0, SHR_30, SHR_48} shr_t;

  typedef struct packed {
    logic    start;
    ser_op_t op;
    shr_t    shr;
  } ser_req_t;

  typedef struct packed {
    logic start;
    logic rotate;
  } cor_req_t;

  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000};

  localparam logic signed [63:0] INV_GAIN_Q30 = 64'sd652032874;
  localparam logic signed [63:0] Q30_ONE      = 64'sd1073741824;
  localparam logic signed [31:0] QUARTER_TURN = 32'sh4000_0000;
  localparam logic signed [37:0] H_MAX        = {1'b0, {37{1'b1}}};
  localparam logic signed [37:0] H_MIN        = {1'b1, 37'd0};

endpackage
`default_nettype wire

// ===== rtl/core/e2g_serial.sv =====
`default_nettype none
// shared bit-serial multiply, divide and square root, one bit per cycle
module e2g_serial (
  input  logic               clk,
  input  logic               rst_n,
  input  e2g_pkg::ser_req_t  req,
  input  logic [79:0]        opa,
  input  logic [63:0]        opb,
  output logic               done,
  output logic [79:0]        res
);

  localparam logic [5:0] MUL_LAST  = 6'd48;
  localparam logic [5:0] DIV_LAST  = 6'd63;
  localparam logic [5:0] SQRT_LAST = 6'd39;

  logic                busy_r, done_r, sat_r;
  logic [5:0]          cnt_r, last;
  e2g_pkg::ser_op_t    op_r;
  e2g_pkg::shr_t       shr_r;
  logic [63:0]         mcand_r, acc_r, nlo_r, q_r;
  logic [48:0]         mq_r;
  logic [32:0]         r_r, d_r, r_nxt;
  logic [79:0]         rad_r;
  logic [41:0]         rem_r, rem_nxt;
  logic [39:0]         root_r;
  logic [64:0]         msum;
  logic [33:0]         r2, rd;
  logic [43:0]         rem2, trial, rsub;
  logic                dge, sge;
  logic [112:0]        prod;

  always_comb begin
    msum    = {1'b0, acc_r} + (mq_r[0] ? {1'b0, mcand_r} : 65'd0);
    r2      = {r_r, nlo_r[63]};
    dge     = r2 >= {1'b0, d_r};
    rd      = r2 - {1'b0, d_r};
    r_nxt   = dge ? rd[32:0] : r2[32:0];
    rem2    = {rem_r, rad_r[79:78]};
    trial   = {2'b00, root_r, 2'b01};
    sge     = rem2 >= trial;
    rsub    = rem2 - trial;
    rem_nxt = sge ? rsub[41:0] : rem2[41:0];
    prod    = {acc_r, mq_r};
  end

  always_comb begin
    unique case (op_r)
      e2g_pkg::SER_MUL:  last = MUL_LAST;
      e2g_pkg::SER_DIV:  last = DIV_LAST;
      e2g_pkg::SER_SQRT: last = SQRT_LAST;
      default:           last = 6'd0;
    endcase
  end

  always_comb begin
    res = '0;
    unique case (op_r)
      e2g_pkg::SER_MUL: begin
        case (shr_r)
          e2g_pkg::SHR_30: res = prod[109:30];
          e2g_pkg::SHR_48: res = {15'd0, prod[112:48]};
          default:         res = prod[79:0];
        endcase
      end
      e2g_pkg::SER_DIV:  res = sat_r ? {16'd0, {64{1'b1}}} : {16'd0, q_r};
      e2g_pkg::SER_SQRT: res = {40'd0, root_r};
      default:           res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r) begin
        if (req.start) begin
          busy_r  <= 1'b1;
          cnt_r   <= '0;
          op_r    <= req.op;
          shr_r   <= req.shr;
          mcand_r <= opa[63:0];
          mq_r    <= opb[48:0];
          acc_r   <= '0;
          nlo_r   <= opa[63:0];
          d_r     <= opb[32:0];
          r_r     <= {17'd0, opa[79:64]};
          sat_r   <= {17'd0, opa[79:64]} >= opb[32:0];
          q_r     <= '0;
          rad_r   <= opa;
          rem_r   <= '0;
          root_r  <= '0;
        end
      end else begin
        acc_r  <= msum[64:1];
        mq_r   <= {msum[0], mq_r[48:1]};
        r_r    <= r_nxt;
        nlo_r  <= {nlo_r[62:0], 1'b0};
        q_r    <= {q_r[62:0], dge};
        rem_r  <= rem_nxt;
        root_r <= {root_r[38:0], sge};
        rad_r  <= {rad_r[77:0], 2'b00};
        cnt_r  <= cnt_r + 6'd1;
        if (cnt_r == last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;

endmodule
`default_nettype wire

// ===== rtl/core/e2g_cordic.sv =====
`default_nettype none
// cordic: vectoring gives atan2, rotation gives sin and cos, one micro-rotation per cycle
module e2g_cordic (
  input  logic                clk,
  input  logic                rst_n,
  input  e2g_pkg::cor_req_t   req,
  input  logic signed [63:0]  in_x,
  input  logic signed [63:0]  in_y,
  input  logic signed [31:0]  in_ang,
  output logic                done,
  output logic signed [31:0]  ang_o,
  output logic signed [31:0]  sin_o,
  output logic [30:0]         cos_o
);

  typedef enum logic [1:0] {CS_IDLE, CS_NORM, CS_ITER} cst_t;

  cst_t               st_r;
  logic signed [63:0] x_r, y_r, xs, ys, ay, x_nxt, y_nxt;
  logic signed [33:0] z_r, tab, z_nxt;
  logic [4:0]         i_r;
  logic               rot_r, half_r, done_r, neg_dir, low_mag;

  always_comb begin
    xs      = x_r >>> i_r;
    ys      = y_r >>> i_r;
    tab     = $signed({2'b00, e2g_pkg::ATAN_TAB[i_r]});
    neg_dir = rot_r ? z_r[33] : (y_r > 64'sd0);
    if (neg_dir) begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + tab;
    end else begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - tab;
    end
    ay      = y_r[63] ? -y_r : y_r;
    low_mag = (x_r[63:58] == 6'd0) && (ay[63:58] == 6'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= CS_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        CS_IDLE: begin
          if (req.start) begin
            i_r    <= '0;
            rot_r  <= req.rotate;
            half_r <= 1'b0;
            if (req.rotate) begin
              x_r  <= e2g_pkg::INV_GAIN_Q30;
              y_r  <= '0;
              z_r  <= 34'(in_ang);
              st_r <= CS_ITER;
            end else begin
              z_r <= '0;
              if (in_x == 64'sd0 && in_y == 64'sd0) begin
                x_r    <= '0;
                y_r    <= '0;
                done_r <= 1'b1;
              end else if (in_x < 64'sd0) begin
                // left half plane: turn by half a turn first
                x_r    <= -in_x;
                y_r    <= -in_y;
                half_r <= 1'b1;
                st_r   <= CS_NORM;
              end else begin
                x_r  <= in_x;
                y_r  <= in_y;
                st_r <= CS_NORM;
              end
            end
          end
        end
        CS_NORM: begin
          if (low_mag) begin
            x_r <= x_r <<< 1;
            y_r <= y_r <<< 1;
          end else begin
            st_r <= CS_ITER;
          end
        end
        CS_ITER: begin
          x_r <= x_nxt;
          y_r <= y_nxt;
          z_r <= z_nxt;
          i_r <= i_r + 5'd1;
          if (i_r == 5'd31) begin
            st_r   <= CS_IDLE;
            done_r <= 1'b1;
          end
        end
        default: st_r <= CS_IDLE;
      endcase
    end
  end

  always_comb begin
    ang_o = z_r[31:0] ^ {half_r, 31'd0};
    if (y_r > e2g_pkg::Q30_ONE)       sin_o = 32'sh4000_0000;
    else if (y_r < -e2g_pkg::Q30_ONE) sin_o = -32'sh4000_0000;
    else                              sin_o = y_r[31:0];
    if (x_r > e2g_pkg::Q30_ONE)       cos_o = 31'h4000_0000;
    else if (x_r < 64'sd0)            cos_o = '0;
    else                              cos_o = x_r[30:0];
  end

  assign done = done_r;

endmodule
`default_nettype wire

// ===== rtl/core/ecef_to_geodetic_core.sv =====
`default_nettype none
// earth-centred x, y, z (mm) to geodetic latitude, longitude and height
// channels: an item is taken when start is high and busy is low; the result
// appears for one cycle with out_valid high and cannot be held off, so the
// receiver must take it then. the cfg port writes a register per cycle with
// cfg_we; index 0 semi-major axis, 1 semi-minor axis, 2 eccentricity squared
// (fraction of 2^48), index 3 is ignored. write it only while the block idles.
// a point on the polar axis returns its result in the next cycle with
// out_on_axis set. otherwise the item runs through one cordic (one
// micro-rotation a cycle) and one bit-serial multiply/divide/sqrt unit (one
// bit a cycle), in turn: setup (longitude, rho, first latitude), then up to
// ITERATIONS latitude steps, fewer when latitude settles early, then the
// closing height pass. the atan2 normalisation shifts one bit a cycle and so
// its length depends on the size of the point. busy stays high until the
// result cycle. reset loads the ellipsoid registers with wgs-84 and idles
// the block.
`include "ecef_to_geodetic_core_assert.svh"
module ecef_to_geodetic_core #(
  parameter int ITERATIONS = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [37:0] in_x_mm,
  input  logic signed [37:0] in_y_mm,
  input  logic signed [37:0] in_z_mm,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [47:0]        cfg_wdata,
  output logic               out_valid,
  output logic signed [31:0] out_lat_angle,
  output logic signed [31:0] out_lon_angle,
  output logic signed [37:0] out_height_mm,
  output logic               out_on_axis
);

  localparam int IW = $clog2(ITERATIONS + 1);
  localparam logic [IW-1:0] LAST_IT = IW'(ITERATIONS - 1);
  localparam logic [1:0] CFG_SEMI_MAJOR = 2'd0;
  localparam logic [1:0] CFG_SEMI_MINOR = 2'd1;
  localparam logic [1:0] CFG_ECC_SQ     = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_LON, S_SQX, S_SQY, S_RHO, S_RB, S_LAT0, S_SC,
    S_S2, S_ES2, S_Q, S_NR, S_EN, S_T, S_NL, S_HD
  } state_t;

  state_t             st_r;
  logic [32:0]        semi_major_r, semi_minor_r;
  logic [47:0]        ecc_r;
  logic signed [37:0] x_r, y_r, z_r;
  logic signed [31:0] lat_r, lon_r, s_r;
  logic [30:0]        c_r;
  logic [75:0]        sq_r;
  logic [38:0]        rho_r;
  logic [56:0]        n_r;
  logic [IW-1:0]      it_r;
  logic               final_r;
  logic               out_valid_r, out_on_axis_r;
  logic signed [31:0] out_lat_r, out_lon_r;
  logic signed [37:0] out_h_r;

  e2g_pkg::ser_req_t  ser_req_r;
  logic [79:0]        ser_a_r, ser_res;
  logic [63:0]        ser_b_r;
  logic               ser_done;
  e2g_pkg::cor_req_t  cor_req_r;
  logic signed [63:0] cor_x_r, cor_y_r;
  logic signed [31:0] cor_ang_r, cor_ang, cor_sin;
  logic [30:0]        cor_cos;
  logic               cor_done;

  logic [37:0]        abs_x, abs_y, abs_z;
  logic [31:0]        abs_sin_new, abs_s;
  logic [76:0]        sum_sq;
  logic [48:0]        w_val;
  logic [63:0]        z64, t64;
  logic signed [63:0] zt, hdiff;
  logic signed [31:0] nl_clamp;
  logic signed [38:0] axis_diff;
  logic signed [37:0] axis_h, hd_h;
  logic               in_axis;

  e2g_serial u_serial (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (ser_req_r),
    .opa  (ser_a_r),
    .opb  (ser_b_r),
    .done (ser_done),
    .res  (ser_res)
  );

  e2g_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (cor_req_r),
    .in_x  (cor_x_r),
    .in_y  (cor_y_r),
    .in_ang(cor_ang_r),
    .done  (cor_done),
    .ang_o (cor_ang),
    .sin_o (cor_sin),
    .cos_o (cor_cos)
  );

  always_comb begin
    abs_x       = x_r[37] ? (~x_r + 38'd1) : x_r;
    abs_y       = y_r[37] ? (~y_r + 38'd1) : y_r;
    abs_z       = in_z_mm[37] ? (~in_z_mm + 38'd1) : in_z_mm;
    abs_sin_new = cor_sin[31] ? (~cor_sin + 32'd1) : cor_sin;
    abs_s       = s_r[31] ? (~s_r + 32'd1) : s_r;
    sum_sq      = {1'b0, sq_r} + {1'b0, ser_res[75:0]};
    w_val       = 49'h1_0000_0000_0000 - {1'b0, ser_res[47:0]};
    z64         = {{26{z_r[37]}}, z_r};
    t64         = {7'd0, ser_res[56:0]};
    zt          = s_r[31] ? $signed(z64 - t64) : $signed(z64 + t64);
    if (cor_ang > e2g_pkg::QUARTER_TURN)       nl_clamp = e2g_pkg::QUARTER_TURN;
    else if (cor_ang < -e2g_pkg::QUARTER_TURN) nl_clamp = -e2g_pkg::QUARTER_TURN;
    else                                       nl_clamp = cor_ang;
    in_axis   = (in_x_mm == 38'sd0) && (in_y_mm == 38'sd0);
    axis_diff = $signed({1'b0, abs_z}) - $signed({6'd0, semi_minor_r});
    axis_h    = (axis_diff > 39'sd137438953471) ? e2g_pkg::H_MAX : axis_diff[37:0];
    // quotient above 2^62 (or saturated) means the height is off the scale
    hdiff     = $signed({1'b0, ser_res[62:0]}) - $signed({7'd0, n_r});
    if (ser_res[63:0] > 64'h4000_0000_0000_0000) hd_h = e2g_pkg::H_MAX;
    else if (hdiff > 64'sd137438953471)          hd_h = e2g_pkg::H_MAX;
    else if (hdiff < -64'sd137438953472)         hd_h = e2g_pkg::H_MIN;
    else                                         hd_h = hdiff[37:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_IDLE;
      ser_req_r    <= '{start: 1'b0, op: e2g_pkg::SER_MUL, shr: e2g_pkg::SHR_0};
      cor_req_r    <= '{start: 1'b0, rotate: 1'b0};
      out_valid_r  <= 1'b0;
      semi_major_r <= 33'd6378137000;
      semi_minor_r <= 33'd6356752314;
      ecc_r        <= 48'd1884300451805;
    end else begin
      ser_req_r.start <= 1'b0;
      cor_req_r.start <= 1'b0;
      out_valid_r     <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SEMI_MAJOR: semi_major_r <= cfg_wdata[32:0];
          CFG_SEMI_MINOR: semi_minor_r <= cfg_wdata[32:0];
          CFG_ECC_SQ:     ecc_r        <= cfg_wdata;
          default: ;
        endcase
      end
      unique case (st_r)
        S_IDLE: begin
          if (start) begin
            x_r <= in_x_mm;
            y_r <= in_y_mm;
            z_r <= in_z_mm;
            if (in_axis) begin
              out_lat_r     <= in_z_mm[37] ? -e2g_pkg::QUARTER_TURN : e2g_pkg::QUARTER_TURN;
              out_lon_r     <= '0;
              out_h_r       <= axis_h;
              out_on_axis_r <= 1'b1;
              out_valid_r   <= 1'b1;
            end else begin
              cor_req_r <= '{start: 1'b1, rotate: 1'b0};
              cor_x_r   <= 64'(in_x_mm);
              cor_y_r   <= 64'(in_y_mm);
              st_r      <= S_LON;
            end
          end
        end
        S_LON: begin
          if (cor_done) begin
            lon_r     <= cor_ang;
            ser_req_r <= '{start: 1'b1, op: e2g_pkg::SER_MUL, shr: e2g_pkg::SHR_0};
            ser_a_r   <= 80'(abs_x);
            ser_b_r   <= 64'(abs_x);
            st_r      <= S_SQX;
          end
        end
        S_SQX: begin
          if (ser_done) begin
            sq_r      <= ser_res[75:0];
            ser_req_r <= '{start: 1'b1, op: e2g_pkg::SER_MUL, shr: e2g_pkg::SHR_0};
            ser_a_r   <= 80'(abs_y);
            ser_b_r   <= 64'(abs_y);
            st_r      <= S_SQY;
          end
        end
        S_SQY: begin
          if (ser_done) begin
            ser_req_r <= '{start: 1'b1, op: e2g_pkg::SER_SQRT, shr: e2g_pkg::SHR_0};
            ser_a_r   <= 80'(sum_sq);
            st_r      <= S_RHO;
          end
        end
        S_RHO: begin
          if (ser_done) begin
            rho_r     <= ser_res[38:0];
            ser_req_r <= '{start: 1'b1, op: e2g_pkg::SER_MUL, shr: e2g_pkg::SHR_48};
            ser_a_r   <= 80'(ser_res[38:0]);
            ser_b_r   <= 64'(49'h1_0000_0000_0000 - {1'b0, ecc_r});
            st_r      <= S_RB;
          end
        end
        S_RB: begin
          if (ser_done) begin
            // bowring start point: atan2(z, rho*(1-e2))
            cor_req_r <= '{start: 1'b1, rotate: 1'b0};
            cor_x_r   <= 64'(ser_res[38:0]);
            cor_y_r   <= z64;
            st_r      <= S_LAT0;
          end
        end
        S_LAT0: begin
          if (cor_done) begin
            lat_r     <= cor_ang;
            it_r      <= '0;
            final_r   <= 1'b0;
            cor_req_r <= '{start: 1'b1, rotate: 1'b1};
            cor_ang_r <= cor_ang;
            st_r      <= S_SC;
          end
        end
        S_SC: begin
          if (cor_done) begin
            s_r       <= cor_sin;
            c_r       <= cor_cos;
            ser_req_r <= '{start: 1'b1, op: e2g_pkg::SER_MUL, shr: e2g_pkg::SHR_30};
            ser_a_r   <= 80'(abs_sin_new[30:0]);
            ser_b_r   <= 64'(abs_sin_new[30:0]);
            st_r      <= S_S2;
          end
        end
        S_S2: begin
          if (ser_done) begin
            ser_req_r <= '{start: 1'b1, op: e2g_pkg::SER_MUL, shr: e2g_pkg::SHR_30};
            ser_a_r   <= 80'(ecc_r);
            ser_b_r   <= 64'(ser_res[30:0]);
            st_r      <= S_ES2;
          end
        end
        S_ES2: begin
          if (ser_done) begin
            ser_req_r <= '{start: 1'b1, op: e2g_pkg::SER_SQRT, shr: e2g_pkg::SHR_0};
            ser_a_r   <= {15'd0, w_val, 16'd0};
            st_r      <= S_Q;
          end
        end
        S_Q: begin
          if (ser_done) begin
            // n = a * 2^32 / q
            ser_req_r <= '{start: 1'b1, op: e2g_pkg::SER_DIV, shr: e2g_pkg::SHR_0};
            ser_a_r   <= {15'd0, semi_major_r[32], semi_major_r[31:0], 32'd0};
            ser_b_r   <= 64'(ser_res[32:0]);
            st_r      <= S_NR;
          end
        end
        S_NR: begin
          if (ser_done) begin
            n_r <= ser_res[56:0];
            if (final_r) begin
              if (c_r == 31'd0) begin
                out_lat_r     <= lat_r;
                out_lon_r     <= lon_r;
                out_h_r       <= e2g_pkg::H_MAX;
                out_on_axis_r <= 1'b0;
                out_valid_r   <= 1'b1;
                st_r          <= S_IDLE;
              end else begin
                ser_req_r <= '{start: 1'b1, op: e2g_pkg::SER_DIV, shr: e2g_pkg::SHR_0};
                ser_a_r   <= {11'd0, rho_r[38:34], rho_r[33:0], 30'd0};
                ser_b_r   <= 64'(c_r);
                st_r      <= S_HD;
              end
            end else begin
              ser_req_r <= '{start: 1'b1, op: e2g_pkg::SER_MUL, shr: e2g_pkg::SHR_48};
              ser_a_r   <= 80'(ser_res[56:0]);
              ser_b_r   <= 64'(ecc_r);
              st_r      <= S_EN;
            end
          end
        end
        S_EN: begin
          if (ser_done) begin
            ser_req_r <= '{start: 1'b1, op: e2g_pkg::SER_MUL, shr: e2g_pkg::SHR_30};
            ser_a_r   <= 80'(ser_res[56:0]);
            ser_b_r   <= 64'(abs_s[30:0]);
            st_r      <= S_T;
          end
        end
        S_T: begin
          if (ser_done) begin
            cor_req_r <= '{start: 1'b1, rotate: 1'b0};
            cor_x_r   <= 64'(rho_r);
            cor_y_r   <= zt;
            st_r      <= S_NL;
          end
        end
        S_NL: begin
          if (cor_done) begin
            cor_req_r <= '{start: 1'b1, rotate: 1'b1};
            st_r      <= S_SC;
            // an unchanged latitude ends the refinement early
            if (cor_ang == lat_r || it_r == LAST_IT) begin
              final_r   <= 1'b1;
              lat_r     <= nl_clamp;
              cor_ang_r <= nl_clamp;
            end else begin
              it_r      <= it_r + 1'b1;
              lat_r     <= cor_ang;
              cor_ang_r <= cor_ang;
            end
          end
        end
        S_HD: begin
          if (ser_done) begin
            out_lat_r     <= lat_r;
            out_lon_r     <= lon_r;
            out_h_r       <= hd_h;
            out_on_axis_r <= 1'b0;
            out_valid_r   <= 1'b1;
            st_r          <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign busy          = (st_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_lat_angle = out_lat_r;
  assign out_lon_angle = out_lon_r;
  assign out_height_mm = out_h_r;
  assign out_on_axis   = out_on_axis_r;

  `E2G_ASSERT(a_result_when_idle, clk, rst_n, !out_valid || !busy)
  `E2G_ASSERT_NEXT(a_off_axis_runs, clk, rst_n, start && !busy && !in_axis, busy && !out_valid)
  `E2G_ASSERT_NEXT(a_single_strobe, clk, rst_n, out_valid && !start, !out_valid)
  `E2G_ASSERT(a_lat_range, clk, rst_n, !out_valid || (out_lat_angle <= e2g_pkg::QUARTER_TURN && out_lat_angle >= -e2g_pkg::QUARTER_TURN))

endmodule
`default_nettype wire
